>>> src/dklp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dklp_pkg;
  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_DEL = 3'd1, OP_LOOK = 3'd2, OP_CHG = 3'd3,
    OP_PRES = 3'd4, OP_ABS = 3'd5
  } op_e;
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_DELETED = 2'd3;
  localparam logic [1:0] RS_OK = 2'd0;
  localparam logic [1:0] RS_NF = 2'd1;
  localparam logic [1:0] RS_FULL = 2'd2;
  localparam int ID_W = 31;
  localparam int CLS_W = 16;
  localparam int NAME_W = 29;
  localparam int CNT_W = 11;
endpackage
`default_nettype wire

>>> src/dklp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module dklp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/dual_key_linear_probe_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Dual-key linear probing record table (id table and name table).
// Command channel: a transaction is taken when start is high and busy low.
// The op, student_id, class_no and name_code ports are sampled then.
// Each transaction gives exactly one result, shown for one cycle with
// done high; the receiver cannot stall, so it must take it then.
// Each probed slot takes an address step, a registered read and a compare.
// A name lookup probes the id table; change class also writes back; add finds
// a free name slot, then a free id slot; delete probes the id table, then the
// linked name slot; mark present and mark absent probe the name table and read
// the linked id record. An unused op answers without probing. A search that
// finds nothing walks up to TABLE_SIZE slots. busy drops in the cycle done is
// high, so the next transaction can be taken then. Reset: after rst the block
// clears all TABLE_SIZE slots of both status stores; busy stays high meanwhile.
// present_count counts records marked present and returns with every result.
module dual_key_linear_probe_table #(
  parameter int TABLE_SIZE = 1024
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [2:0]                 op,
  input  wire logic [dklp_pkg::ID_W-1:0]  student_id,
  input  wire logic [dklp_pkg::CLS_W-1:0] class_no,
  input  wire logic [dklp_pkg::NAME_W-1:0] name_code,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [dklp_pkg::ID_W-1:0]       found_id,
  output logic [dklp_pkg::CLS_W-1:0]      found_class,
  output logic [dklp_pkg::NAME_W-1:0]     found_name,
  output logic [dklp_pkg::CNT_W-1:0]      present_count
);
  import dklp_pkg::*;
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int RW = AW + 1;
  localparam logic [AW-1:0] LAST = AW'(TABLE_SIZE - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_FREE_N, S_FREE_I, S_FIND, S_NLINK, S_WB, S_OUT, S_WAIT,
    S_CHECK
  } state_t;
  // probe target: 0 free name, 1 free id, 2 live id, 3 live name by key,
  // 4 name slot by link
  typedef enum logic [2:0] {
    P_FREE_N, P_FREE_I, P_ID, P_NAME, P_LINK
  } probe_t;

  state_t state;
  probe_t ptype;
  logic [2:0]        op_r;
  logic [ID_W-1:0]   id_r;
  logic [CLS_W-1:0]  cls_r;
  logic [NAME_W-1:0] name_r;
  logic [AW-1:0]     idx, hit_is, hit_ns;
  logic [RW-1:0]     cnt;
  logic [AW-1:0]     raddr;

  logic [1:0]        ist_rd, nst_rd;
  logic [ID_W-1:0]   ikey_rd;
  logic [CLS_W-1:0]  icls_rd;
  logic [NAME_W-1:0] iname_rd;
  logic [NAME_W-1:0] nkey_rd;
  logic [AW-1:0]     nlink_rd;

  logic ist_we, nst_we, irec_we, icls_we, nrec_we;
  logic [AW-1:0] ist_wa, nst_wa;
  logic [1:0] ist_wd, nst_wd;
  logic [CLS_W-1:0] icls_wd;

  dklp_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_ist (.clk, .we(ist_we), .waddr(ist_wa),
    .wdata(ist_wd), .raddr, .rdata(ist_rd));
  dklp_ram #(.WIDTH(ID_W), .DEPTH(TABLE_SIZE)) u_ikey (.clk, .we(irec_we),
    .waddr(hit_is), .wdata(id_r), .raddr, .rdata(ikey_rd));
  dklp_ram #(.WIDTH(CLS_W), .DEPTH(TABLE_SIZE)) u_icls (.clk, .we(icls_we),
    .waddr(hit_is), .wdata(icls_wd), .raddr, .rdata(icls_rd));
  dklp_ram #(.WIDTH(NAME_W), .DEPTH(TABLE_SIZE)) u_iname (.clk, .we(irec_we),
    .waddr(hit_is), .wdata(name_r), .raddr, .rdata(iname_rd));
  dklp_ram #(.WIDTH(2), .DEPTH(TABLE_SIZE)) u_nst (.clk, .we(nst_we), .waddr(nst_wa),
    .wdata(nst_wd), .raddr, .rdata(nst_rd));
  dklp_ram #(.WIDTH(NAME_W), .DEPTH(TABLE_SIZE)) u_nkey (.clk, .we(nrec_we),
    .waddr(hit_ns), .wdata(name_r), .raddr, .rdata(nkey_rd));
  dklp_ram #(.WIDTH(AW), .DEPTH(TABLE_SIZE)) u_nlink (.clk, .we(nrec_we),
    .waddr(hit_ns), .wdata(hit_is), .raddr, .rdata(nlink_rd));

  // single probe compare unit
  logic [1:0] pst;
  logic live, pmatch, pfree;
  always_comb begin
    pst = (ptype == P_FREE_I || ptype == P_ID) ? ist_rd : nst_rd;
    live = (pst == ST_ABSENT) || (pst == ST_PRESENT);
    pfree = (pst == ST_EMPTY) || (pst == ST_DELETED);
    case (ptype)
      P_ID:    pmatch = live && (ikey_rd == id_r);
      P_NAME:  pmatch = live && (nkey_rd == name_r);
      P_LINK:  pmatch = live && (nlink_rd == hit_is);
      default: pmatch = pfree;
    endcase
  end

  // writeback and clear control
  logic wb_go;
  always_comb begin
    ist_we = 1'b0; ist_wa = hit_is; ist_wd = ST_ABSENT;
    nst_we = 1'b0; nst_wa = hit_ns; nst_wd = ST_ABSENT;
    irec_we = 1'b0; nrec_we = 1'b0; icls_we = 1'b0; icls_wd = cls_r;
    if (state == S_CLR) begin
      ist_we = 1'b1; ist_wa = idx; ist_wd = ST_EMPTY;
      nst_we = 1'b1; nst_wa = idx; nst_wd = ST_EMPTY;
    end else if (wb_go) begin
      case (op_r)
        OP_ADD: begin
          ist_we = 1'b1; nst_we = 1'b1; irec_we = 1'b1; nrec_we = 1'b1; icls_we = 1'b1;
        end
        OP_DEL: begin
          ist_we = 1'b1; ist_wd = ST_DELETED;
          nst_we = (status == RS_OK); nst_wd = ST_DELETED;
        end
        OP_CHG: icls_we = 1'b1;
        OP_PRES, OP_ABS: begin
          ist_we = 1'b1; nst_we = 1'b1;
          ist_wd = (op_r == OP_PRES) ? ST_PRESENT : ST_ABSENT;
          nst_wd = ist_wd;
        end
        default: ;
      endcase
    end
  end
  assign wb_go = (state == S_WB);
  assign busy = (state != S_IDLE);

  logic [1:0] is_st;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      idx <= '0;
      done <= 1'b0;
      present_count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          idx <= (idx == LAST) ? '0 : idx + AW'(1);
          if (idx == LAST) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op_r <= op; id_r <= student_id; cls_r <= class_no; name_r <= name_code;
            status <= RS_NF; found_id <= '0; found_class <= '0; found_name <= '0;
            cnt <= '0;
            case (op)
              OP_ADD: begin
                ptype <= P_FREE_N;
                idx <= AW'(name_code % NAME_W'(TABLE_SIZE));
                state <= S_WAIT;
              end
              OP_DEL, OP_LOOK, OP_CHG: begin
                ptype <= P_ID;
                idx <= AW'(student_id % ID_W'(TABLE_SIZE));
                state <= S_WAIT;
              end
              OP_PRES, OP_ABS: begin
                ptype <= P_NAME;
                idx <= AW'(name_code % NAME_W'(TABLE_SIZE));
                state <= S_WAIT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_WAIT: state <= S_FIND;   // RAM address settles, data next
        S_FIND: state <= S_CHECK;
        S_CHECK: begin
          if (pmatch) begin
            cnt <= '0;
            case (ptype)
              P_FREE_N: begin
                hit_ns <= idx; ptype <= P_FREE_I;
                idx <= AW'(id_r % ID_W'(TABLE_SIZE)); state <= S_WAIT;
              end
              P_FREE_I: begin
                hit_is <= idx; status <= RS_OK; state <= S_WB;
              end
              P_ID: begin
                hit_is <= idx; is_st <= ist_rd; status <= RS_OK;
                case (op_r)
                  OP_DEL: begin
                    found_class <= icls_rd; found_name <= iname_rd;
                    ptype <= P_LINK; idx <= AW'(iname_rd % NAME_W'(TABLE_SIZE));
                    status <= RS_NF; state <= S_WAIT;
                  end
                  OP_LOOK: begin found_name <= iname_rd; state <= S_OUT; end
                  default: state <= S_WB;
                endcase
              end
              P_LINK: begin
                hit_ns <= idx; status <= RS_OK; state <= S_WB;
              end
              default: begin
                hit_ns <= idx; hit_is <= nlink_rd; idx <= nlink_rd;
                status <= RS_OK; state <= S_NLINK;
              end
            endcase
          end else if ((ptype == P_ID || ptype == P_NAME || ptype == P_LINK)
                       && pst == ST_EMPTY || cnt == RW'(TABLE_SIZE - 1)) begin
            if (ptype == P_LINK) begin
              state <= S_WB;   // record removed, name slot left alone
            end else begin
              status <= (ptype == P_FREE_N || ptype == P_FREE_I) ? RS_FULL : RS_NF;
              found_class <= '0; found_name <= '0;
              state <= S_OUT;
            end
          end else begin
            cnt <= cnt + RW'(1);
            idx <= (idx == LAST) ? '0 : idx + AW'(1);
            state <= S_WAIT;
          end
        end
        S_NLINK: state <= S_FREE_N;
        S_FREE_N: state <= S_FREE_I;
        S_FREE_I: begin
          found_id <= ikey_rd; found_class <= icls_rd; is_st <= ist_rd;
          state <= S_WB;
        end
        S_WB: begin
          if (op_r == OP_DEL) begin
            status <= RS_OK;
            if (is_st == ST_PRESENT && present_count != '0)
              present_count <= present_count - CNT_W'(1);
          end else if (op_r == OP_PRES && is_st == ST_ABSENT) begin
            present_count <= present_count + CNT_W'(1);
          end else if (op_r == OP_ABS && is_st == ST_PRESENT && present_count != '0) begin
            present_count <= present_count - CNT_W'(1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
  assign raddr = idx;
endmodule
`default_nettype wire

>>> src/dklp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module dklp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [10:0] present_count
);
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_status_range: assert property (@(posedge clk) disable iff (rst) done |-> status != 2'd3)
    else $error("bad status");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("no busy");
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    !busy |=> $stable(present_count)) else $error("count");
endmodule
bind dual_key_linear_probe_table dklp_checker u_chk (.clk, .rst, .start, .busy, .done,
  .status, .present_count);
`default_nettype wire

>>> test/dual_key_linear_probe_table_tb.sv
`timescale 1ns / 1ps
module dual_key_linear_probe_table_tb;
  import dklp_pkg::*;

  localparam int SLOTS = 1024;
  localparam int RAND_ITEMS = 420;
  localparam longint CYCLE_LIMIT = 100000000;

  typedef struct packed {
    logic [1:0]        st;
    logic [ID_W-1:0]   fid;
    logic [CLS_W-1:0]  fcls;
    logic [NAME_W-1:0] fname;
    logic [CNT_W-1:0]  cnt;
  } outcome_t;

  typedef struct {
    logic [2:0]        op;
    logic [ID_W-1:0]   id;
    logic [CLS_W-1:0]  cls;
    logic [NAME_W-1:0] name;
    bit                typed;
    outcome_t          res;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [2:0] op = '0;
  logic [ID_W-1:0] student_id = '0;
  logic [CLS_W-1:0] class_no = '0;
  logic [NAME_W-1:0] name_code = '0;
  wire busy, done;
  wire [1:0] status;
  wire [ID_W-1:0] found_id;
  wire [CLS_W-1:0] found_class;
  wire [NAME_W-1:0] found_name;
  wire [CNT_W-1:0] present_count;

  dual_key_linear_probe_table uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .student_id(student_id), .class_no(class_no), .name_code(name_code),
    .done(done), .status(status), .found_id(found_id), .found_class(found_class),
    .found_name(found_name), .present_count(present_count)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // mirror of both tables
  logic [1:0]        id_st   [SLOTS];
  logic [ID_W-1:0]   id_key  [SLOTS];
  logic [CLS_W-1:0]  id_cls  [SLOTS];
  logic [NAME_W-1:0] id_name [SLOTS];
  logic [1:0]        nm_st   [SLOTS];
  logic [NAME_W-1:0] nm_key  [SLOTS];
  int                nm_link [SLOTS];
  int                live_present;

  outcome_t pending[$];
  int errors = 0;
  longint cycles = 0;
  bit quiet = 0;

  function automatic int free_slot(bit in_names, int key);
    int i;
    logic [1:0] s;
    i = key % SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      s = in_names ? nm_st[i] : id_st[i];
      if (s == ST_EMPTY || s == ST_DELETED) return i;
      i = (i + 1) % SLOTS;
    end
    return -1;
  endfunction

  function automatic int live_slot(bit in_names, bit by_link, int key, int want);
    int i;
    int v;
    logic [1:0] s;
    i = key % SLOTS;
    for (int n = 0; n < SLOTS; n++) begin
      s = in_names ? nm_st[i] : id_st[i];
      if (s == ST_EMPTY) return -1;
      v = in_names ? (by_link ? nm_link[i] : int'(nm_key[i])) : int'(id_key[i]);
      if ((s == ST_ABSENT || s == ST_PRESENT) && v == want) return i;
      i = (i + 1) % SLOTS;
    end
    return -1;
  endfunction

  function automatic outcome_t apply_command(logic [2:0] c, logic [ID_W-1:0] id,
                                             logic [CLS_W-1:0] cls,
                                             logic [NAME_W-1:0] name);
    outcome_t r;
    int is;
    int ns;
    r = '0;
    r.st = RS_NF;
    case (c)
      OP_ADD: begin
        ns = free_slot(1, int'(name));
        is = free_slot(0, int'(id));
        if (ns < 0 || is < 0) begin
          r.st = RS_FULL;
        end else begin
          id_st[is] = ST_ABSENT;
          id_key[is] = id;
          id_cls[is] = cls;
          id_name[is] = name;
          nm_st[ns] = ST_ABSENT;
          nm_key[ns] = name;
          nm_link[ns] = is;
          r.st = RS_OK;
        end
      end
      OP_DEL: begin
        is = live_slot(0, 0, int'(id), int'(id));
        if (is >= 0) begin
          ns = live_slot(1, 1, int'(id_name[is]), is);
          r.fcls = id_cls[is];
          r.fname = id_name[is];
          if (id_st[is] == ST_PRESENT && live_present > 0) live_present--;
          id_st[is] = ST_DELETED;
          if (ns >= 0) nm_st[ns] = ST_DELETED;
          r.st = RS_OK;
        end
      end
      OP_LOOK: begin
        is = live_slot(0, 0, int'(id), int'(id));
        if (is >= 0) begin
          r.fname = id_name[is];
          r.st = RS_OK;
        end
      end
      OP_CHG: begin
        is = live_slot(0, 0, int'(id), int'(id));
        if (is >= 0) begin
          id_cls[is] = cls;
          r.st = RS_OK;
        end
      end
      OP_PRES, OP_ABS: begin
        ns = live_slot(1, 0, int'(name), int'(name));
        if (ns >= 0) begin
          is = nm_link[ns];
          if (c == OP_PRES) begin
            if (id_st[is] == ST_ABSENT) live_present++;
            id_st[is] = ST_PRESENT;
            nm_st[ns] = ST_PRESENT;
          end else begin
            if (id_st[is] == ST_PRESENT && live_present > 0) live_present--;
            id_st[is] = ST_ABSENT;
            nm_st[ns] = ST_ABSENT;
          end
          r.fid = id_key[is];
          r.fcls = id_cls[is];
          r.st = RS_OK;
        end
      end
      default: ;
    endcase
    r.cnt = live_present[CNT_W-1:0];
    return r;
  endfunction

  task automatic issue(row_t t);
    outcome_t p;
    while (!quiet && $urandom_range(99) < 26) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    op <= t.op;
    student_id <= t.id;
    class_no <= t.cls;
    name_code <= t.name;
    do @(posedge clk); while (busy);
    p = apply_command(t.op, t.id, t.cls, t.name);
    pending.push_back(t.typed ? t.res : p);
  endtask

  function automatic row_t mk(logic [2:0] c, logic [ID_W-1:0] id, logic [CLS_W-1:0] cls,
                              logic [NAME_W-1:0] name);
    row_t t;
    t.op = c;
    t.id = id;
    t.cls = cls;
    t.name = name;
    t.typed = 0;
    t.res = '0;
    return t;
  endfunction

  function automatic row_t mkx(logic [2:0] c, logic [ID_W-1:0] id, logic [CLS_W-1:0] cls,
                               logic [NAME_W-1:0] name, outcome_t res);
    row_t t;
    t = mk(c, id, cls, name);
    t.typed = 1;
    t.res = res;
    return t;
  endfunction

  always @(posedge clk) begin
    outcome_t e;
    outcome_t a;
    cycles <= cycles + 1;
    if (!rst && done) begin
      a = '{status, found_id, found_class, found_name, present_count};
      if (pending.size() == 0) begin
        $display("%0t: unexpected transaction, actual %h", $time, a);
        errors++;
      end else begin
        e = pending.pop_front();
        if (e.st !== a.st) begin
          $display("%0t: status exp %0d act %0d", $time, e.st, a.st);
          errors++;
        end
        if (e.fid !== a.fid) begin
          $display("%0t: found_id exp %h act %h", $time, e.fid, a.fid);
          errors++;
        end
        if (e.fcls !== a.fcls) begin
          $display("%0t: found_class exp %h act %h", $time, e.fcls, a.fcls);
          errors++;
        end
        if (e.fname !== a.fname) begin
          $display("%0t: found_name exp %h act %h", $time, e.fname, a.fname);
          errors++;
        end
        if (e.cnt !== a.cnt) begin
          $display("%0t: present_count exp %0d act %0d", $time, e.cnt, a.cnt);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  localparam logic [ID_W-1:0] ID_MAX = '1;
  localparam logic [NAME_W-1:0] NAME_MAX = 29'd308915775;

  row_t dir_rows[$];
  logic [ID_W-1:0] id_pool[64];
  logic [NAME_W-1:0] name_pool[64];
  logic [NAME_W-1:0] fill_names[$];

  initial begin
    int pick;
    logic [2:0] c;
    logic [ID_W-1:0] id;
    logic [NAME_W-1:0] name;
    int k;

    for (int i = 0; i < SLOTS; i++) begin
      id_st[i] = ST_EMPTY;
      nm_st[i] = ST_EMPTY;
      id_key[i] = '0;
      id_cls[i] = '0;
      id_name[i] = '0;
      nm_key[i] = '0;
      nm_link[i] = 0;
    end
    live_present = 0;

    dir_rows.push_back(mkx(OP_LOOK, 0, 0, 0, '{RS_NF, 0, 0, 0, 0}));
    dir_rows.push_back(mkx(OP_ADD, ID_MAX, 16'hFFFF, NAME_MAX, '{RS_OK, 0, 0, 0, 0}));
    dir_rows.push_back(mk(OP_ADD, 0, 0, 0));
    dir_rows.push_back(mk(OP_ADD, 1024, 16'h00A5, 1024));
    dir_rows.push_back(mk(OP_LOOK, 1024, 0, 0));
    dir_rows.push_back(mkx(OP_PRES, 0, 0, NAME_MAX, '{RS_OK, ID_MAX, 16'hFFFF, 0, 1}));
    dir_rows.push_back(mk(OP_PRES, 0, 0, NAME_MAX));
    dir_rows.push_back(mk(OP_ABS, 0, 0, 0));
    dir_rows.push_back(mk(OP_CHG, 0, 16'h1234, 0));
    dir_rows.push_back(mk(OP_PRES, 0, 0, 0));
    dir_rows.push_back(mk(OP_DEL, 0, 0, 0));
    dir_rows.push_back(mk(OP_LOOK, 1024, 0, 0));
    dir_rows.push_back(mkx(OP_DEL, 5, 0, 0, '{RS_NF, 0, 0, 0, 1}));
    dir_rows.push_back(mk(OP_CHG, 77, 16'h5555, 0));
    dir_rows.push_back(mk(OP_PRES, 0, 0, 77));
    dir_rows.push_back(mk(OP_ABS, 0, 0, NAME_MAX));
    dir_rows.push_back(mkx(3'd6, ID_MAX, 16'hFFFF, NAME_MAX, '{RS_NF, 0, 0, 0, 0}));
    dir_rows.push_back(mkx(3'd7, 0, 0, 0, '{RS_NF, 0, 0, 0, 0}));
    dir_rows.push_back(mk(OP_ADD, 2048, 16'h8001, 0));
    dir_rows.push_back(mk(OP_PRES, 0, 0, 0));
    dir_rows.push_back(mk(OP_DEL, ID_MAX, 0, 0));
    dir_rows.push_back(mk(OP_DEL, 2048, 0, 0));

    for (int i = 0; i < 64; i++) begin
      id_pool[i] = ID_W'(($urandom & 32'h7FFFFC00) | $urandom_range(0, 95));
      name_pool[i] = NAME_W'($urandom_range(0, 301000) * 1024 + $urandom_range(0, 95));
    end

    repeat (5) @(posedge clk);
    rst <= 0;

    foreach (dir_rows[i]) issue(dir_rows[i]);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      quiet = (n >= 150 && n < 300);
      pick = $urandom_range(99);
      id = id_pool[$urandom_range(63)];
      name = name_pool[$urandom_range(63)];
      if ($urandom_range(9) == 0) id = ID_W'($urandom);
      if ($urandom_range(9) == 0) name = NAME_W'($urandom_range(0, 308915775));
      if (pick < 20) c = OP_ADD;
      else if (pick < 40) c = OP_DEL;
      else if (pick < 55) c = OP_LOOK;
      else if (pick < 67) c = OP_CHG;
      else if (pick < 83) c = OP_PRES;
      else if (pick < 98) c = OP_ABS;
      else c = 3'($urandom_range(6, 7));
      issue(mk(c, id, 16'($urandom), name));
    end
    quiet = 0;

    // fill both tables, then overflow and a wrapping miss
    k = 0;
    while (free_slot(0, 0) >= 0 && free_slot(1, 0) >= 0) begin
      name = NAME_W'(((300 + k) % SLOTS) + SLOTS * $urandom_range(0, 301000));
      issue(mk(OP_ADD, ID_W'(($urandom & 32'h7FFFFC00) | ((200 + k) % SLOTS)),
               16'($urandom), name));
      fill_names.push_back(name);
      k++;
    end
    issue(mk(OP_ADD, ID_MAX, 16'hFFFF, NAME_MAX));
    issue(mk(OP_LOOK, 31'h7FFFFFFE, 0, 0));
    issue(mk(OP_PRES, 0, 0, 29'h1FFFFFF));
    issue(mk(OP_PRES, 0, 0, fill_names[0]));
    issue(mk(OP_ABS, 0, 0, fill_names[0]));

    @(posedge clk);
    start <= 0;
    while (pending.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

>>> filelist.f
src/dklp_pkg.sv
src/dklp_ram.sv
src/dual_key_linear_probe_table.sv
src/dklp_checker.sv
test/dual_key_linear_probe_table_tb.sv
